// File: design/nrb_pkg.sv
// Package for the network controller register block: widths, offsets, codes,
// PHY answer constants and the command and status structs.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package nrb_pkg;

   localparam int NRB_REG_WORDS = 256;

   localparam int ADDR_W = 10;
   localparam int DATA_W = 32;
   localparam int SIZE_W = 2;
   localparam int WIDX_W = ADDR_W - 2;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [SIZE_W-1:0] SIZE_BYTE = 2'd0;
   localparam logic [SIZE_W-1:0] SIZE_HALF = 2'd1;
   localparam logic [SIZE_W-1:0] SIZE_WORD = 2'd2;
   localparam logic [SIZE_W-1:0] SIZE_BAD  = 2'd3;

   localparam logic [ADDR_W-1:0] OFF_STATUS  = 10'h000;
   localparam logic [ADDR_W-1:0] OFF_MASK    = 10'h004;
   localparam logic [ADDR_W-1:0] OFF_SETUP5  = 10'h130;
   localparam logic [ADDR_W-1:0] OFF_SETUP3  = 10'h134;
   localparam logic [ADDR_W-1:0] OFF_CONTROL = 10'h144;
   localparam logic [ADDR_W-1:0] OFF_MIISTAT = 10'h180;
   localparam logic [ADDR_W-1:0] OFF_MIICTL  = 10'h190;
   localparam logic [ADDR_W-1:0] OFF_MIIDATA = 10'h194;

   localparam logic [WIDX_W-1:0] IDX_STATUS  = OFF_STATUS[ADDR_W-1:2];
   localparam logic [WIDX_W-1:0] IDX_MASK    = OFF_MASK[ADDR_W-1:2];
   localparam logic [WIDX_W-1:0] IDX_SETUP5  = OFF_SETUP5[ADDR_W-1:2];
   localparam logic [WIDX_W-1:0] IDX_SETUP3  = OFF_SETUP3[ADDR_W-1:2];
   localparam logic [WIDX_W-1:0] IDX_CONTROL = OFF_CONTROL[ADDR_W-1:2];
   localparam logic [WIDX_W-1:0] IDX_MIICTL  = OFF_MIICTL[ADDR_W-1:2];

   localparam logic [DATA_W-1:0] CTL_IDLE_VALUE  = 32'h0000_0008;
   localparam logic [DATA_W-1:0] SETUP3_KICK     = 32'h0020_0010;
   localparam logic [DATA_W-1:0] SETUP5_KICK     = 32'h8000_0000;
   localparam logic [DATA_W-1:0] MIICTL_BUSY     = 32'h0001_0000;
   localparam logic [DATA_W-1:0] PHY_ABSENT      = 32'hFFFF_FFFF;
   localparam logic [DATA_W-1:0] PHY_STATUS_VAL  = 32'h0000_0024;
   localparam logic [DATA_W-1:0] PHY_ABILITY_VAL = 32'h0000_03E0;

   localparam logic [4:0] PHY_OWN_ADDR    = 5'd1;
   localparam logic [4:0] PHY_REG_STATUS  = 5'd1;
   localparam logic [4:0] PHY_REG_ADVERT  = 5'd4;
   localparam logic [4:0] PHY_REG_PARTNER = 5'd5;

   typedef struct packed {
      logic clear_en;
      logic load_req;
      logic commit;
   } nrb_cmd_type;

   typedef struct packed {
      logic clear_done;
   } nrb_status_type;

endpackage

`default_nettype wire

// File: design/nrb_channels.sv
// Handshake channels of the register block: the access request and the response.
// Depends on nrb_pkg for the field widths.
`default_nettype none

interface nrb_req_if;
   import nrb_pkg::*;

   logic              valid;
   logic              ready;
   logic              command;
   logic [ADDR_W-1:0] address;
   logic [SIZE_W-1:0] access_size;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, command, address, access_size, write_data, input ready);
   modport sink   (input valid, command, address, access_size, write_data, output ready);
endinterface

interface nrb_rsp_if;
   import nrb_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic              irq_line;

   modport source (output valid, read_data, irq_line, input ready);
   modport sink   (input valid, read_data, irq_line, output ready);
endinterface

`default_nettype wire

// File: design/nic_register_block_with_mii.sv
// Top level of the network controller register block with its fixed MII PHY.
// Depends on nrb_pkg, nrb_channels (nrb_req_if, nrb_rsp_if), nrb_ctrl and nrb_dp.
//
//   Channel   Direction  Word carries
//   req_bus   in         command, address, access_size, write_data
//   rsp_bus   out        read_data, irq_line
//
// An access first reads the addressed word from the single-port register store,
// then merges, writes back and loads the response. After reset a clearing pass
// zeroes all REG_WORDS words of the store, one word a cycle; req_bus.ready stays
// low until it ends. A waiting response is held in its register, and a new word
// is taken while it waits but not executed until the response register is free.
`default_nettype none

module nic_register_block_with_mii #(
   parameter int REG_WORDS = nrb_pkg::NRB_REG_WORDS
) (
   input wire        clock,
   input wire        reset,
   nrb_req_if.sink   req_bus,
   nrb_rsp_if.source rsp_bus
);
   import nrb_pkg::*;

   nrb_cmd_type    cmd;
   nrb_status_type status;

   nrb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   nrb_dp #(
      .REG_WORDS (REG_WORDS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_command     (req_bus.command),
      .req_address     (req_bus.address),
      .req_access_size (req_bus.access_size),
      .req_write_data  (req_bus.write_data),
      .rsp_read_data   (rsp_bus.read_data),
      .rsp_irq_line    (rsp_bus.irq_line)
   );

endmodule

`default_nettype wire

// File: design/nrb_ctrl.sv
// Controller of the register block: clearing pass, request acceptance,
// execution and the response valid flag.
// Depends on nrb_pkg for the command and status structs.
`default_nettype none

module nrb_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   output nrb_pkg::nrb_cmd_type    cmd,
   input  nrb_pkg::nrb_status_type status
);
   import nrb_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd          = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: design/nrb_dp.sv
// Datapath of the register block: the register store, shadow copies of the
// words with side effects, access decode, interrupt level and response register.
// Depends on nrb_pkg for offsets, codes and the command and status structs.
`default_nettype none

module nrb_dp #(
   parameter int REG_WORDS = 256
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire nrb_pkg::nrb_cmd_type        cmd,
   output nrb_pkg::nrb_status_type          status,
   input  wire                              req_command,
   input  wire  [nrb_pkg::ADDR_W-1:0]       req_address,
   input  wire  [nrb_pkg::SIZE_W-1:0]       req_access_size,
   input  wire  [nrb_pkg::DATA_W-1:0]       req_write_data,
   output logic [nrb_pkg::DATA_W-1:0]       rsp_read_data,
   output logic                             rsp_irq_line
);
   import nrb_pkg::*;

   localparam int MIDX_W = $clog2(REG_WORDS);

   logic [DATA_W-1:0] store_mem [REG_WORDS];

   logic [MIDX_W-1:0] clr_cnt_ff, clr_cnt_in;

   logic              cmd_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [SIZE_W-1:0] size_ff;
   logic [DATA_W-1:0] wdata_ff;
   logic [DATA_W-1:0] word_ff;

   logic [DATA_W-1:0] status_sh_ff, mask_sh_ff, setup3_sh_ff, miictl_sh_ff;
   logic              irq_ff, irq_in;

   logic [DATA_W-1:0] read_data_ff, read_data_in;
   logic              irq_out_ff;

   logic [DATA_W-1:0] lane_word, rep_data, byte_mask, merged, cleared, phy_word;
   logic [3:0]        byte_en;
   logic              size_ok, do_write, do_read;
   logic              wr_en;
   logic [WIDX_W-1:0] wr_idx;
   logic [DATA_W-1:0] wr_data;
   logic              refresh;
   logic [DATA_W-1:0] new_status, new_mask;

   assign status.clear_done = (clr_cnt_ff == MIDX_W'(REG_WORDS - 1));
   assign clr_cnt_in        = cmd.clear_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;

   assign size_ok  = (size_ff != SIZE_BAD);
   assign do_write = size_ok && (cmd_ff == CMD_WRITE);
   assign do_read  = size_ok && (cmd_ff == CMD_READ);

   always_comb begin
      case (size_ff)
         SIZE_BYTE: begin
            rep_data = {4{wdata_ff[7:0]}};
            byte_en  = 4'b0001 << addr_ff[1:0];
            case (addr_ff[1:0])
               2'd0:    lane_word = {24'b0, word_ff[7:0]};
               2'd1:    lane_word = {24'b0, word_ff[15:8]};
               2'd2:    lane_word = {24'b0, word_ff[23:16]};
               default: lane_word = {24'b0, word_ff[31:24]};
            endcase
         end
         SIZE_HALF: begin
            rep_data  = {2{wdata_ff[15:0]}};
            byte_en   = addr_ff[1] ? 4'b1100 : 4'b0011;
            lane_word = addr_ff[1] ? {16'b0, word_ff[31:16]} : {16'b0, word_ff[15:0]};
         end
         default: begin
            rep_data  = wdata_ff;
            byte_en   = 4'b1111;
            lane_word = word_ff;
         end
      endcase
   end

   assign byte_mask = {{8{byte_en[3]}}, {8{byte_en[2]}}, {8{byte_en[1]}}, {8{byte_en[0]}}};
   assign merged    = (word_ff & ~byte_mask) | (rep_data & byte_mask);
   assign cleared   = word_ff & ~(rep_data & byte_mask);

   always_comb begin
      if (miictl_sh_ff[9:5] != PHY_OWN_ADDR) begin
         phy_word = PHY_ABSENT;
      end else if (miictl_sh_ff[15]) begin
         phy_word = '0;
      end else if (miictl_sh_ff[4:0] == PHY_REG_STATUS) begin
         phy_word = PHY_STATUS_VAL;
      end else if (miictl_sh_ff[4:0] == PHY_REG_ADVERT ||
                   miictl_sh_ff[4:0] == PHY_REG_PARTNER) begin
         phy_word = PHY_ABILITY_VAL;
      end else begin
         phy_word = '0;
      end
   end

   always_comb begin
      read_data_in = '0;
      if (do_read) begin
         if (addr_ff == OFF_MIIDATA) begin
            read_data_in = phy_word;
         end else if (addr_ff == OFF_MIICTL) begin
            read_data_in = lane_word & ~MIICTL_BUSY;
         end else if (addr_ff == OFF_MIISTAT) begin
            read_data_in = '0;
         end else begin
            read_data_in = lane_word;
         end
      end
   end

   always_comb begin
      wr_en      = do_write;
      wr_idx     = addr_ff[ADDR_W-1:2];
      wr_data    = merged;
      refresh    = 1'b0;
      new_status = status_sh_ff;
      new_mask   = mask_sh_ff;
      if (addr_ff == OFF_MIIDATA) begin
         wr_en = 1'b0;
      end else if (addr_ff == OFF_CONTROL) begin
         if (wdata_ff[2]) begin
            wr_idx  = IDX_CONTROL;
            wr_data = CTL_IDLE_VALUE;
         end else if (wdata_ff[1]) begin
            wr_idx  = IDX_STATUS;
            wr_data = '0;
         end else if (wdata_ff == '0 && setup3_sh_ff == SETUP3_KICK) begin
            wr_idx  = IDX_SETUP5;
            wr_data = SETUP5_KICK;
         end
      end else if (addr_ff == OFF_MASK) begin
         refresh  = do_write;
         new_mask = merged;
      end else if (addr_ff == OFF_STATUS) begin
         refresh    = do_write;
         wr_data    = cleared;
         new_status = cleared;
      end
   end

   assign irq_in = refresh ? ((new_mask != '0) && (new_status != '0)) : irq_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         store_mem[clr_cnt_ff] <= '0;
      end else if (cmd.commit && wr_en) begin
         store_mem[MIDX_W'(wr_idx)] <= wr_data;
      end
      if (cmd.load_req) begin
         word_ff  <= store_mem[MIDX_W'(req_address[ADDR_W-1:2])];
         cmd_ff   <= req_command;
         addr_ff  <= req_address;
         size_ff  <= req_access_size;
         wdata_ff <= req_write_data;
      end
      if (cmd.commit) begin
         read_data_ff <= read_data_in;
         irq_out_ff   <= irq_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff   <= '0;
         irq_ff       <= 1'b0;
         status_sh_ff <= '0;
         mask_sh_ff   <= '0;
         setup3_sh_ff <= '0;
         miictl_sh_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
         if (cmd.commit) begin
            irq_ff <= irq_in;
            if (wr_en) begin
               if (wr_idx == IDX_STATUS) begin
                  status_sh_ff <= wr_data;
               end
               if (wr_idx == IDX_MASK) begin
                  mask_sh_ff <= wr_data;
               end
               if (wr_idx == IDX_SETUP3) begin
                  setup3_sh_ff <= wr_data;
               end
               if (wr_idx == IDX_MIICTL) begin
                  miictl_sh_ff <= wr_data;
               end
            end
         end
      end
   end

   assign rsp_read_data = read_data_ff;
   assign rsp_irq_line  = irq_out_ff;

endmodule

`default_nettype wire
